// ----- design/cla_pkg.sv -----
// ----------------------------------------------------------------------------
// cla_pkg: console line assembler shared definitions
// Command codes, status codes, character constants and the control and
// result structures passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_FETCH = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_PEEK  = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd126;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // take the word on the input channel
    logic run;     // a line is being streamed out
    logic emit;    // load the next line character into the output register
  } cla_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;      // output register can take a new word
    logic start_stream;  // the word on the input would stream characters
    logic last_char;     // the character at the read pointer is the final one
  } cla_sts_t;

  typedef struct packed {
    logic [1:0] status;
    logic       char_valid;
    logic [6:0] out_char;
    logic       last;
    logic [5:0] cur_length;
    logic       ready_flag;
    logic       overflow_flag;
  } out_word_t;

endpackage

`default_nettype wire

// ----- design/console_line_assembler.sv -----
// ----------------------------------------------------------------------------
// console_line_assembler: console input line assembler
// Collects received bytes into an editable line and streams it out on
// fetch or peek commands.
// ----------------------------------------------------------------------------
// Push, clear, and any fetch or peek that yields no characters return a
// single word. A fetch or peek that returns n characters is accepted and
// then delivers one character word per cycle while the output is taken;
// the next command is not accepted until the last character has been loaded
// into the output register, and the line store's read port is registered.
// A command is accepted only when the output register is empty or its word
// is taken in that same cycle, so a stalled output also stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_assembler
  import cla_pkg::*;
#(
  parameter int DEPTH = 64
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // rx_byte[7:0], max_length[14:8], zero
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // status[1:0], out_char[8:2],
                                       // cur_length[14:9], ready_flag[15],
                                       // overflow_flag[16], zero
  output logic             out_tuser,  // char_valid
  output logic             out_tlast   // last
);

  cla_cmd_t  cmd;
  cla_sts_t  sts;
  out_word_t out_word;

  cla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cla_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .func       (in_tuser),
    .rx_byte    (in_tdata[7:0]),
    .max_length (in_tdata[14:8]),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_word   (out_word)
  );

  assign out_tdata = {7'd0, out_word.overflow_flag, out_word.ready_flag,
                      out_word.cur_length, out_word.out_char, out_word.status};
  assign out_tuser = out_word.char_valid;
  assign out_tlast = out_word.last;

endmodule

`default_nettype wire

// ----- design/cla_ctrl.sv -----
// ----------------------------------------------------------------------------
// cla_ctrl: console line assembler controller
// Accepts command words and sequences the read-out of a stored line, one
// character per cycle while the output side takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_ctrl
  import cla_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire cla_sts_t sts,
  output cla_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t state_r;

  always_comb begin
    in_tready  = (state_r == S_IDLE) && sts.out_free;
    cmd.accept = in_tready && in_tvalid;
    cmd.run    = (state_r == S_STREAM);
    cmd.emit   = cmd.run && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept && sts.start_stream) begin
            state_r <= S_STREAM;
          end
        end
        S_STREAM: begin
          if (cmd.emit && sts.last_char) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cla_dp.sv -----
// ----------------------------------------------------------------------------
// cla_dp: console line assembler datapath
// Line store, length and flag registers, command decode, read pointer and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_dp
  import cla_pkg::*;
#(
  parameter int DEPTH = 64
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] func,
  input  wire logic [7:0] rx_byte,
  input  wire logic [6:0] max_length,
  input  wire logic       out_tready,
  input  wire cla_cmd_t   cmd,
  output cla_sts_t        sts,
  output logic            out_valid,
  output out_word_t       out_word
);

  localparam int LW = $clog2(DEPTH);

  logic [6:0] line_store [DEPTH];
  logic [6:0] rd_data_r;

  logic [LW-1:0] len_r, len_nxt;
  logic          rdy_r, rdy_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] ptr_r, addr_sel;
  logic [LW-1:0] last_idx_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic          wr_en;
  logic [1:0]    acc_status;
  logic          streams;
  logic [LW-1:0] copy_n;
  logic          fill_single;

  // Decode the word on the input and the line state that follows it.
  always_comb begin
    len_nxt    = len_r;
    rdy_nxt    = rdy_r;
    ovf_nxt    = ovf_r;
    wr_en      = 1'b0;
    acc_status = ST_OK;
    streams    = 1'b0;
    copy_n     = len_r;
    if (7'(len_r) >= max_length) begin
      copy_n = LW'(max_length - 7'd1);
    end
    unique case (func_t'(func))
      FUNC_PUSH: begin
        if (!rdy_r) begin
          if (rx_byte == CH_CR || rx_byte == CH_LF) begin
            rdy_nxt = 1'b1;
          end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
            if (len_r != '0) begin
              len_nxt = len_r - LW'(1);
            end
          end else if (rx_byte >= CH_FIRST && rx_byte <= CH_LAST) begin
            if (len_r >= LW'(DEPTH - 1)) begin
              ovf_nxt = 1'b1;
              rdy_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              len_nxt = len_r + LW'(1);
            end
          end
        end
      end
      FUNC_CLEAR: begin
        len_nxt = '0;
        rdy_nxt = 1'b0;
        ovf_nxt = 1'b0;
      end
      FUNC_FETCH, FUNC_PEEK: begin
        if (max_length == 7'd0) begin
          acc_status = ST_ERROR;
        end else if (func_t'(func) == FUNC_FETCH && !rdy_r) begin
          acc_status = ST_BUSY;
        end else begin
          streams = (copy_n != '0);
          if (func_t'(func) == FUNC_FETCH) begin
            len_nxt = '0;
            rdy_nxt = 1'b0;
            ovf_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  assign sts.out_free     = !out_valid_r || out_tready;
  assign sts.start_stream = streams;
  assign sts.last_char    = (ptr_r == last_idx_r);

  assign fill_single = cmd.accept && !streams;

  // The read data register holds the entry at the read pointer; both load from the same selected address.
  always_comb begin
    addr_sel = '0;
    if (cmd.run) begin
      if (cmd.emit) begin
        addr_sel = sts.last_char ? '0 : ptr_r + LW'(1);
      end else begin
        addr_sel = ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      line_store[len_r] <= rx_byte[6:0];
    end
    rd_data_r <= line_store[addr_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rdy_r       <= 1'b0;
      ovf_r       <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r <= addr_sel;
      if (cmd.accept) begin
        len_r <= len_nxt;
        rdy_r <= rdy_nxt;
        ovf_r <= ovf_nxt;
      end
      if (fill_single || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && streams) begin
      last_idx_r <= copy_n - LW'(1);
    end
    if (fill_single) begin
      out_word_r.status        <= acc_status;
      out_word_r.char_valid    <= 1'b0;
      out_word_r.out_char      <= '0;
      out_word_r.last          <= 1'b1;
      out_word_r.cur_length    <= 6'(len_nxt);
      out_word_r.ready_flag    <= rdy_nxt;
      out_word_r.overflow_flag <= ovf_nxt;
    end else if (cmd.emit) begin
      out_word_r.status        <= ST_OK;
      out_word_r.char_valid    <= 1'b1;
      out_word_r.out_char      <= rd_data_r;
      out_word_r.last          <= sts.last_char;
      out_word_r.cur_length    <= 6'(len_r);
      out_word_r.ready_flag    <= rdy_r;
      out_word_r.overflow_flag <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
